### hdl/gws_pkg.sv
package gws_pkg;

   localparam int FUNC_W   = 2;
   localparam int COORD_W  = 6;
   localparam int LETTER_W = 8;
   localparam int POS_W    = 5;
   localparam int MASK_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int SIZE_W   = 7;
   localparam int LEN_W    = 6;
   localparam int DIR_W    = 3;

   localparam logic [FUNC_W-1:0] FUNC_GRID_WR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WORD_WR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;

   localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;

   // direction codes, also the bit positions in the found mask
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
   localparam logic [DIR_W-1:0] DIR_UL    = 3'd4;
   localparam logic [DIR_W-1:0] DIR_UR    = 3'd5;
   localparam logic [DIR_W-1:0] DIR_DL    = 3'd6;
   localparam logic [DIR_W-1:0] DIR_DR    = 3'd7;
   localparam logic [DIR_W-1:0] DIR_LAST  = DIR_DR;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_INC,
      STEP_DEC
   } step_type;

   function automatic step_type row_step(input logic [DIR_W-1:0] dir);
      step_type step;
      unique case (dir) inside
         DIR_UP, DIR_UL, DIR_UR:   step = STEP_DEC;
         DIR_DOWN, DIR_DL, DIR_DR: step = STEP_INC;
         default:                  step = STEP_HOLD;
      endcase
      return step;
   endfunction

   function automatic step_type col_step(input logic [DIR_W-1:0] dir);
      step_type step;
      unique case (dir) inside
         DIR_LEFT, DIR_UL, DIR_DL:  step = STEP_DEC;
         DIR_RIGHT, DIR_UR, DIR_DR: step = STEP_INC;
         default:                   step = STEP_HOLD;
      endcase
      return step;
   endfunction

endpackage

### hdl/gws_ifs.sv
interface gws_req_if;
   import gws_pkg::*;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [COORD_W-1:0]  row;
   logic [COORD_W-1:0]  col;
   logic [LETTER_W-1:0] letter;
   logic [POS_W-1:0]    word_pos;
   logic                word_end;

   modport source (output valid, func, row, col, letter, word_pos, word_end, input ready);
   modport sink   (input valid, func, row, col, letter, word_pos, word_end, output ready);
endinterface

interface gws_rsp_if;
   import gws_pkg::*;
   logic               valid;
   logic               ready;
   logic [MASK_W-1:0]  found_mask;
   logic [COUNT_W-1:0] match_count;

   modport source (output valid, found_mask, match_count, input ready);
   modport sink   (input valid, found_mask, match_count, output ready);
endinterface

interface gws_csr_if;
   import gws_pkg::*;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] grid_size;

   modport source (output valid, grid_size, input ready);
   modport sink   (input valid, grid_size, output ready);
endinterface

### hdl/grid_word_search_eight_dir.sv
// Eight-direction word search. Grid letters (func 0) and word letters (func 1) are loaded one
// per request; a search request (func 2) returns the mask of directions in which the loaded
// word reads from the start cell inside a grid of csr grid_size rows and columns. One request
// is handled at a time: ready is high only while idle. A search checks the eight directions in
// turn through a single grid read port and one byte comparator: each compared letter takes a
// read state and a compare state, a step off the grid ends that direction in the read state,
// and each direction stops early at the first mismatch. The response stays registered until
// taken. The grid_size register is to be written only while the block is idle; the block
// itself does not enforce this.
module grid_word_search_eight_dir #(
   parameter int MAX_GRID = 64,
   parameter int MAX_WORD = 32
) (
   input logic        clock,
   input logic        reset,
   gws_req_if.sink    req_chan,
   gws_rsp_if.source  rsp_chan,
   gws_csr_if.sink    csr_chan
);
   import gws_pkg::*;

   localparam int RW         = $clog2(MAX_GRID) + 1;
   localparam int GRID_DEPTH = MAX_GRID * MAX_GRID;
   localparam int AW         = $clog2(GRID_DEPTH);
   localparam int KW         = $clog2(MAX_WORD);

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]   grid_size_ff, grid_size_in;
   logic [LEN_W-1:0]    word_len_ff, word_len_in;
   logic [RW-1:0]       row0_ff, row0_in;
   logic [RW-1:0]       col0_ff, col0_in;
   logic [RW-1:0]       r_ff, r_in;
   logic [RW-1:0]       c_ff, c_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [LETTER_W-1:0] grid_q_ff;
   logic [LETTER_W-1:0] word_q_ff;

   logic [LETTER_W-1:0] grid_mem [GRID_DEPTH];
   logic [LETTER_W-1:0] word_mem [MAX_WORD];

   logic           req_fire;
   logic           csr_fire;
   logic           rsp_fire;
   logic [RW-1:0]  grid_lim;
   logic           start_ok;
   logic           grid_we;
   logic           word_we;
   logic [AW-1:0]  grid_waddr;
   logic [AW-1:0]  grid_raddr;
   logic [KW-1:0]  word_waddr;
   logic           off_grid;
   logic           mismatch;
   logic           last_letter;
   logic           dir_done;
   step_type       rstep;
   step_type       cstep;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // grid sizes above the storage act as the full storage
   always_comb begin
      if (32'(grid_size_ff) > 32'(MAX_GRID)) begin
         grid_lim = RW'(MAX_GRID);
      end else begin
         grid_lim = RW'(grid_size_ff);
      end
   end

   assign start_ok = (word_len_ff != '0) &&
                     (32'(req_chan.row) < 32'(grid_lim)) &&
                     (32'(req_chan.col) < 32'(grid_lim));

   assign grid_we = req_fire && (req_chan.func == FUNC_GRID_WR) &&
                    (32'(req_chan.row) < 32'(MAX_GRID)) &&
                    (32'(req_chan.col) < 32'(MAX_GRID));
   assign word_we = req_fire && (req_chan.func == FUNC_WORD_WR) &&
                    (32'(req_chan.word_pos) < 32'(MAX_WORD));

   assign grid_waddr = AW'(32'(req_chan.row) * 32'(MAX_GRID) + 32'(req_chan.col));
   assign grid_raddr = AW'(32'(r_ff) * 32'(MAX_GRID) + 32'(c_ff));
   assign word_waddr = KW'(req_chan.word_pos);

   assign off_grid    = (r_ff >= grid_lim) || (c_ff >= grid_lim);
   assign mismatch    = (grid_q_ff != word_q_ff);
   assign last_letter = ((k_ff + LEN_W'(1)) == word_len_ff);
   assign dir_done    = ((state_ff == ST_READ) && off_grid) ||
                        ((state_ff == ST_CMP) && (mismatch || last_letter));
   assign rstep       = row_step(dir_ff);
   assign cstep       = col_step(dir_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_chan.func == FUNC_SEARCH) && start_ok) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_READ: begin
            if (!off_grid) begin
               state_in = ST_CMP;
            end else if (dir_ff == DIR_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_CMP: begin
            if (dir_done && (dir_ff == DIR_LAST)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready       = (state_ff == ST_IDLE);
      rsp_chan.valid       = (state_ff == ST_RESP);
      rsp_chan.found_mask  = mask_ff;
      rsp_chan.match_count = count_ff;
      csr_chan.ready       = 1'b1;
   end

   // walk datapath
   always_comb begin
      grid_size_in = csr_fire ? csr_chan.grid_size : grid_size_ff;
      word_len_in  = word_len_ff;
      row0_in      = row0_ff;
      col0_in      = col0_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      dir_in       = dir_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;

      if (word_we && req_chan.word_end) begin
         word_len_in = LEN_W'(req_chan.word_pos) + LEN_W'(1);
      end

      if (req_fire) begin
         row0_in  = RW'(req_chan.row);
         col0_in  = RW'(req_chan.col);
         r_in     = RW'(req_chan.row);
         c_in     = RW'(req_chan.col);
         k_in     = '0;
         dir_in   = DIR_UP;
         mask_in  = '0;
         count_in = '0;
      end else if (dir_done) begin
         // whole word matched in this direction
         if ((state_ff == ST_CMP) && !mismatch) begin
            mask_in[dir_ff] = 1'b1;
            count_in        = count_ff + COUNT_W'(1);
         end
         r_in   = row0_ff;
         c_in   = col0_ff;
         k_in   = '0;
         dir_in = dir_ff + DIR_W'(1);
      end else if (state_ff == ST_CMP) begin
         k_in = k_ff + LEN_W'(1);
         case (rstep)
            STEP_INC: r_in = r_ff + RW'(1);
            STEP_DEC: r_in = r_ff - RW'(1);
            default:  r_in = r_ff;
         endcase
         case (cstep)
            STEP_INC: c_in = c_ff + RW'(1);
            STEP_DEC: c_in = c_ff - RW'(1);
            default:  c_in = c_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_size_ff <= GRID_SIZE_RST;
         word_len_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         grid_size_ff <= grid_size_in;
         word_len_ff  <= word_len_in;
      end
   end

   always_ff @(posedge clock) begin
      row0_ff  <= row0_in;
      col0_ff  <= col0_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      k_ff     <= k_in;
      dir_ff   <= dir_in;
      mask_ff  <= mask_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= req_chan.letter;
      end
      grid_q_ff <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_waddr] <= req_chan.letter;
      end
      word_q_ff <= word_mem[k_ff[KW-1:0]];
   end

endmodule

### hdl/gws_checker.sv
module gws_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gws_pkg::MASK_W-1:0]  rsp_found_mask,
   input logic [gws_pkg::COUNT_W-1:0] rsp_match_count
);

   // a response waits until taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before taken");

   // count agrees with the mask
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_match_count) == $countones(rsp_found_mask)))
      else $error("match count does not agree with mask");

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");

endmodule

bind grid_word_search_eight_dir gws_checker u_gws_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found_mask  (rsp_chan.found_mask),
   .rsp_match_count (rsp_chan.match_count)
);

### tb/sv/tb_grid_word_search_eight_dir.sv
module tb_grid_word_search_eight_dir;
   timeunit 1ns;
   timeprecision 1ps;

   import gws_pkg::*;

   localparam int GRID_DIM = 64;
   localparam int WORD_DIM = 32;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [LETTER_W-1:0] letter;
      logic [POS_W-1:0]    word_pos;
      logic                word_end;
      bit                  drain_first;
   } search_request_type;

   typedef struct {
      logic [MASK_W-1:0]  found_mask;
      logic [COUNT_W-1:0] match_count;
   } search_result_type;

   logic clock = 1'b0;
   logic reset;

   gws_req_if req_bus ();
   gws_rsp_if rsp_bus ();
   gws_csr_if csr_bus ();

   grid_word_search_eight_dir uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   search_request_type requests_waiting [$];
   search_result_type  results_due [$];

   // predictor copy of the block state, updated as requests are accepted
   logic [LETTER_W-1:0] grid_copy [GRID_DIM*GRID_DIM];
   logic [LETTER_W-1:0] word_copy [WORD_DIM];
   int                  word_len_copy = 0;
   int                  grid_size_copy = int'(GRID_SIZE_RST);

   // generator bookkeeping, so that no search reads an unwritten entry
   bit                  grid_known [GRID_DIM*GRID_DIM];
   bit                  word_known [WORD_DIM];
   logic [LETTER_W-1:0] gen_word [WORD_DIM];
   int                  gen_len = 0;
   int                  gen_n = GRID_DIM;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int requests_queued = 0;
   int requests_sent = 0;
   int searches_sent = 0;
   int searches_hit = 0;
   int settings_used = 0;

   function automatic int row_delta(input int d);
      case (d)
         DIR_UP, DIR_UL, DIR_UR:   return -1;
         DIR_DOWN, DIR_DL, DIR_DR: return 1;
         default:                  return 0;
      endcase
   endfunction

   function automatic int col_delta(input int d);
      case (d)
         DIR_LEFT, DIR_UL, DIR_DL:  return -1;
         DIR_RIGHT, DIR_UR, DIR_DR: return 1;
         default:                   return 0;
      endcase
   endfunction

   function automatic logic [MASK_W-1:0] directions_matching(input int r0, input int c0);
      logic [MASK_W-1:0] mask;
      int n, r, c;
      bit ok;
      mask = '0;
      n = (grid_size_copy > GRID_DIM) ? GRID_DIM : grid_size_copy;
      if (word_len_copy == 0 || r0 >= n || c0 >= n)
         return mask;
      for (int d = 0; d <= int'(DIR_LAST); d++) begin
         ok = 1'b1;
         for (int k = 0; k < word_len_copy && ok; k++) begin
            r = r0 + k * row_delta(d);
            c = c0 + k * col_delta(d);
            if (r < 0 || c < 0 || r >= n || c >= n)
               ok = 1'b0;
            else if (grid_copy[r*GRID_DIM + c] !== word_copy[k])
               ok = 1'b0;
         end
         mask[d] = ok;
      end
      return mask;
   endfunction

   task automatic apply_request(input search_request_type rq);
      search_result_type want;
      want.found_mask = '0;
      case (rq.func)
         FUNC_GRID_WR: grid_copy[int'(rq.row)*GRID_DIM + int'(rq.col)] = rq.letter;
         FUNC_WORD_WR: begin
            word_copy[rq.word_pos] = rq.letter;
            if (rq.word_end)
               word_len_copy = int'(rq.word_pos) + 1;
         end
         FUNC_SEARCH: begin
            want.found_mask = directions_matching(int'(rq.row), int'(rq.col));
            searches_sent++;
            if (want.found_mask != '0)
               searches_hit++;
         end
         default: ;
      endcase
      want.match_count = COUNT_W'($countones(want.found_mask));
      results_due.insert(results_due.size(), want);
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      bit take_next;
      search_request_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         take_next = !req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            rq = requests_waiting.pop_front();
            apply_request(rq);
            requests_sent++;
            take_next = 1'b1;
         end
         if (take_next) begin
            if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(requests_waiting[0].drain_first && results_due.size() != 0)) begin
               rq = requests_waiting[0];
               req_bus.valid    <= 1'b1;
               req_bus.func     <= rq.func;
               req_bus.row      <= rq.row;
               req_bus.col      <= rq.col;
               req_bus.letter   <= rq.letter;
               req_bus.word_pos <= rq.word_pos;
               req_bus.word_end <= rq.word_end;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      search_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               note_mismatch("unexpected response mask", -1, int'(rsp_bus.found_mask));
            end else begin
               want = results_due.pop_front();
               if (rsp_bus.found_mask !== want.found_mask)
                  note_mismatch("found_mask", int'(want.found_mask),
                                int'(rsp_bus.found_mask));
               if (rsp_bus.match_count !== want.match_count)
                  note_mismatch("match_count", int'(want.match_count),
                                int'(rsp_bus.match_count));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic int pick_letter();
      // a two-letter alphabet most of the time so partial matches are common
      if ($urandom_range(99) < 70)
         return 'h41 + int'($urandom_range(1));
      return int'($urandom_range(255));
   endfunction

   task automatic queue_request(input logic [FUNC_W-1:0] func, input int row, input int col,
                                input int letter, input int pos,
                                input bit last, input bit drain);
      search_request_type rq;
      rq.func        = func;
      rq.row         = COORD_W'(row);
      rq.col         = COORD_W'(col);
      rq.letter      = LETTER_W'(letter);
      rq.word_pos    = POS_W'(pos);
      rq.word_end    = last;
      rq.drain_first = drain;
      requests_waiting.insert(requests_waiting.size(), rq);
      requests_queued++;
      if (func == FUNC_GRID_WR) begin
         grid_known[row*GRID_DIM + col] = 1'b1;
      end else if (func == FUNC_WORD_WR) begin
         word_known[pos] = 1'b1;
         gen_word[pos] = LETTER_W'(letter);
         if (last)
            gen_len = pos + 1;
      end
   endtask

   task automatic load_word(input int len);
      for (int p = 0; p < len; p++)
         queue_request(FUNC_WORD_WR, $urandom_range(63), $urandom_range(63), pick_letter(), p,
                       p == len - 1, 1'b0);
   endtask

   // fill every word position and grid cell the search may read, then search
   task automatic cover_search(input int row, input int col, input bit drain);
      int r, c;
      for (int p = 0; p < gen_len; p++)
         if (!word_known[p])
            queue_request(FUNC_WORD_WR, 0, 0, pick_letter(), p, 1'b0, 1'b0);
      if (gen_len != 0 && row < gen_n && col < gen_n) begin
         for (int d = 0; d <= int'(DIR_LAST); d++) begin
            for (int k = 0; k < gen_len; k++) begin
               r = row + k * row_delta(d);
               c = col + k * col_delta(d);
               if (r >= 0 && c >= 0 && r < gen_n && c < gen_n && !grid_known[r*GRID_DIM + c])
                  queue_request(FUNC_GRID_WR, r, c, pick_letter(), $urandom_range(31),
                                $urandom_range(99) < 50, 1'b0);
            end
         end
      end
      queue_request(FUNC_SEARCH, row, col, $urandom_range(255), $urandom_range(31),
                    $urandom_range(99) < 50, drain);
   endtask

   function automatic int random_start();
      if (gen_n != 0 && $urandom_range(99) < 85)
         return int'($urandom_range(gen_n - 1));
      return int'($urandom_range(63));
   endfunction

   // write the word along one direction from a start where it fits, then search there
   task automatic plant_and_search();
      int d, r0, c0, span;
      for (int p = 0; p < gen_len; p++)
         if (!word_known[p])
            queue_request(FUNC_WORD_WR, 0, 0, pick_letter(), p, 1'b0, 1'b0);
      if (gen_n == 0 || gen_len == 0 || gen_len > gen_n) begin
         cover_search(random_start(), random_start(), 1'b0);
      end else begin
         d = int'($urandom_range(int'(DIR_LAST)));
         span = gen_len - 1;
         r0 = (row_delta(d) < 0) ? $urandom_range(gen_n - 1, span) :
              (row_delta(d) > 0) ? $urandom_range(gen_n - 1 - span) : $urandom_range(gen_n - 1);
         c0 = (col_delta(d) < 0) ? $urandom_range(gen_n - 1, span) :
              (col_delta(d) > 0) ? $urandom_range(gen_n - 1 - span) : $urandom_range(gen_n - 1);
         for (int k = 0; k < gen_len; k++)
            queue_request(FUNC_GRID_WR, r0 + k * row_delta(d), c0 + k * col_delta(d),
                          int'(gen_word[k]), $urandom_range(31), $urandom_range(99) < 50,
                          1'b0);
         cover_search(r0, c0, $urandom_range(99) < 3);
      end
   endtask

   task automatic wait_idle();
      while (requests_waiting.size() != 0 || results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_grid_size(input int value);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.grid_size <= SIZE_W'(value);
      do @(posedge clock); while (!(csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1));
      csr_bus.valid <= 1'b0;
      grid_size_copy = value;
   endtask

   // budget is the number of requests this phase queues, give or take one action
   task automatic run_phase(input int size, input int idle, input int stall,
                            input int max_len, input int budget);
      int pick, pos, len, phase_end;
      bit last;
      wait_idle();
      write_grid_size(size);
      gen_n = (size > GRID_DIM) ? GRID_DIM : size;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      settings_used++;
      phase_end = requests_queued + budget;
      if (max_len == WORD_DIM) begin
         load_word(WORD_DIM);
         plant_and_search();
      end
      while (requests_queued < phase_end) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            len = $urandom_range(99);
            len = (len < 80) ? $urandom_range((max_len < 4) ? max_len : 4, 1) :
                  (len < 95) ? $urandom_range((max_len < 10) ? max_len : 10, 1) :
                  $urandom_range(max_len, 1);
            load_word(len);
         end else if (pick < 16) begin
            queue_request(FUNC_GRID_WR, $urandom_range(63), $urandom_range(63),
                          $urandom_range(255), $urandom_range(31), $urandom_range(99) < 50,
                          1'b0);
         end else if (pick < 22) begin
            // stray word letter, a stray end mark keeps the length within this phase
            last = ($urandom_range(99) < 50);
            pos = last ? $urandom_range(max_len - 1) : $urandom_range(WORD_DIM - 1);
            queue_request(FUNC_WORD_WR, $urandom_range(63), $urandom_range(63),
                          $urandom_range(255), pos, last, 1'b0);
         end else if (pick < 25) begin
            queue_request(FUNC_UNUSED, $urandom_range(63), $urandom_range(63),
                          $urandom_range(255), $urandom_range(31), $urandom_range(99) < 50,
                          1'b0);
         end else if (pick < 60) begin
            plant_and_search();
         end else begin
            cover_search(random_start(), random_start(), $urandom_range(99) < 3);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_GRID_WR;
      req_bus.row = '0;
      req_bus.col = '0;
      req_bus.letter = '0;
      req_bus.word_pos = '0;
      req_bus.word_end = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.grid_size = GRID_SIZE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: no word yet, unused code, single-letter word, corners, short word
      queue_request(FUNC_SEARCH, 0, 0, 'h00, 0, 1'b0, 1'b0);
      queue_request(FUNC_UNUSED, 63, 63, 'hFF, 31, 1'b1, 1'b0);
      queue_request(FUNC_WORD_WR, 0, 0, 'hFF, 0, 1'b1, 1'b0);
      queue_request(FUNC_GRID_WR, 63, 63, 'hFF, 31, 1'b1, 1'b0);
      queue_request(FUNC_GRID_WR, 0, 0, 'h00, 0, 1'b0, 1'b0);
      queue_request(FUNC_SEARCH, 63, 63, 'h00, 0, 1'b0, 1'b1);
      queue_request(FUNC_SEARCH, 0, 0, 'hFF, 31, 1'b1, 1'b0);
      queue_request(FUNC_WORD_WR, 5, 5, 'h00, 31, 1'b0, 1'b0);
      queue_request(FUNC_WORD_WR, 0, 0, 'h41, 0, 1'b0, 1'b0);
      queue_request(FUNC_WORD_WR, 0, 0, 'h42, 1, 1'b1, 1'b0);
      queue_request(FUNC_GRID_WR, 0, 0, 'h41, 0, 1'b0, 1'b0);
      queue_request(FUNC_GRID_WR, 0, 1, 'h42, 0, 1'b0, 1'b0);
      queue_request(FUNC_GRID_WR, 1, 0, 'h42, 0, 1'b0, 1'b0);
      queue_request(FUNC_GRID_WR, 1, 1, 'h42, 0, 1'b0, 1'b0);
      cover_search(0, 0, 1'b0);
      cover_search(63, 0, 1'b0);
      cover_search(0, 63, 1'b0);

      run_phase(1, 0, 0, 4, 24);
      run_phase(5, 83, 0, 6, 24);
      run_phase(64, 0, 83, 8, 24);
      run_phase(0, 22, 22, 4, 24);
      run_phase(127, 0, 0, 6, 24);
      run_phase(8, 83, 0, WORD_DIM, 24);
      run_phase(100, 22, 22, 6, 24);
      run_phase(2, 0, 83, 3, 24);
      run_phase(64, 0, 0, WORD_DIM, 24);
      run_phase(3, 22, 22, 4, 24);

      wait_idle();
      repeat (40) @(posedge clock);
      $display("ran %0d requests, %0d of them searches (%0d found the word)",
               requests_sent, searches_sent, searches_hit);
      $display("grid size changed %0d times, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("grid_word_search_eight_dir test passed");
      end else begin
         $display("grid_word_search_eight_dir test failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d requests and %0d responses outstanding",
               requests_waiting.size(), results_due.size());
      $display("grid_word_search_eight_dir test failed");
      $finish;
   end

endmodule

### grid_word_search_eight_dir.f
hdl/gws_pkg.sv
hdl/gws_ifs.sv
hdl/grid_word_search_eight_dir.sv
hdl/gws_checker.sv
tb/sv/tb_grid_word_search_eight_dir.sv
